// ===== src/sus_pkg.sv =====
// shared types, codes and constants of the sector unit serializer
package sus_pkg;

  // operation codes of an input word
  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_SECTOR    = 2'd1;
  localparam logic [1:0] OP_POSTPONED = 2'd2;
  localparam logic [1:0] OP_FETCH     = 2'd3;

  // status codes of an output word
  localparam logic [2:0] ST_BYTE    = 3'd0;
  localparam logic [2:0] ST_STARTED = 3'd1;
  localparam logic [2:0] ST_NO_MORE = 3'd2;
  localparam logic [2:0] ST_BAD_LEN = 3'd3;
  localparam logic [2:0] ST_WRITTEN = 3'd4;

  // flag byte decode
  localparam logic [7:0] FLAG_MASK   = 8'hC0;
  localparam logic [7:0] FLAG_FULL   = 8'h80;
  localparam logic [7:0] FLAG_RECORD = 8'h40;

  // fixed sector positions
  localparam logic [7:0] ADDR_FLAG      = 8'd0;
  localparam logic [7:0] ADDR_CMD_HI    = 8'd253;
  localparam logic [7:0] ADDR_CMD_MID   = 8'd254;
  localparam logic [7:0] ADDR_CMD_LO    = 8'd255;
  localparam logic [7:0] ADDR_REC_START = 8'd252;
  localparam logic [7:0] ADDR_LAST      = 8'hFF;

  // unit lengths
  localparam logic [7:0] LEN_FULL  = 8'hFF;
  localparam logic [7:0] LEN_MAX   = 8'd4;
  localparam logic [7:0] LEN_DUMMY = 8'd3;
  localparam logic [7:0] LEN_CHAIN = 8'd2;

  // new-job bit of the next command
  localparam int unsigned NEW_JOB_BIT = 23;

  // line encoding: invert low seven bits, then reorder into bit pairs
  localparam logic [7:0] WIRE_XOR = 8'h7F;
  localparam logic [2:0] PAIR_SRC [8] = '{3'd3, 3'd1, 3'd2, 3'd0, 3'd4, 3'd5, 3'd6, 3'd7};

  // one result word
  typedef struct packed {
    logic [2:0] status;
    logic       is_length;
    logic [7:0] raw_byte;
    logic [7:0] wire_pairs;
    logic       chain_head;
    logic       job_end;
    logic       unit_last;
  } res_t;

  // write port of a byte store
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } mem_wr_t;

  function automatic logic [7:0] encode_pairs(input logic [7:0] raw);
    logic [7:0] inv;
    logic [7:0] enc;
    inv = raw ^ WIRE_XOR;
    for (int k = 0; k < 8; k++) begin
      enc[k] = inv[PAIR_SRC[k]];
    end
    return enc;
  endfunction

endpackage

// ===== src/sus_in_if.sv =====
// input channel: valid/ready handshake with the op word
interface sus_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] address;
  logic [7:0] byte_value;

  modport source (output valid, output op, output address, output byte_value, input ready);
  modport sink (input valid, input op, input address, input byte_value, output ready);
endinterface

// ===== src/sus_out_if.sv =====
// output channel: valid/ready handshake with the result word
interface sus_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        is_length;
  logic [7:0]  raw_byte;
  logic [7:0]  wire_pairs;
  logic        chain_head;
  logic        job_end;
  logic        unit_last;
  logic [23:0] next_command;

  modport source (output valid, output status, output is_length, output raw_byte,
                  output wire_pairs, output chain_head, output job_end, output unit_last,
                  output next_command, input ready);
  modport sink (input valid, input status, input is_length, input raw_byte,
                input wire_pairs, input chain_head, input job_end, input unit_last,
                input next_command, output ready);
endinterface

// ===== src/sus_sub.sv =====
// shared 8-bit subtractor with borrow and zero flags
module sus_sub (
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  output logic [7:0] diff_o,
  output logic       borrow_o,
  output logic       zero_o
);
  logic [8:0] wide;

  // a - b, borrow set when b exceeds a
  assign wide     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = wide[7:0];
  assign borrow_o = wide[8];
  assign zero_o   = (wide[7:0] == 8'd0);
endmodule

// ===== src/sus_sector_mem.sv =====
// 256 x 8 sector store, one write port and one registered read port
module sus_sector_mem (
  input  logic              clk_i,
  input  sus_pkg::mem_wr_t  wr_i,
  input  logic [7:0]        rd_addr_i,
  output logic [7:0]        rd_data_o
);
  import sus_pkg::*;

  logic [7:0] mem [256];
  logic [7:0] rd_data_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
endmodule

// ===== src/sus_pp_mem.sv =====
// postponed unit store with per-entry valid bits, unwritten entries read as zero
module sus_pp_mem #(
  parameter int unsigned DEPTH = 93
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sus_pkg::mem_wr_t  wr_i,
  input  logic [7:0]        rd_addr_i,
  output logic [7:0]        rd_data_o
);
  import sus_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic [7:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic            hit_q;
  logic            hit_d;
  logic [7:0]      rd_data_q;
  logic [IdxW-1:0] widx;
  logic [IdxW-1:0] ridx;
  logic            rd_in_range;

  assign widx        = wr_i.addr[IdxW-1:0];
  assign ridx        = rd_addr_i[IdxW-1:0];
  assign rd_in_range = (rd_addr_i < 8'(DEPTH));
  assign hit_d       = rd_in_range ? valid_q[ridx] : 1'b0;

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[widx] <= 1'b1;
      end
      hit_q <= hit_d;
    end
  end

  // data array
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[widx] <= wr_i.data;
    end
    if (rd_in_range) begin
      rd_data_q <= mem[ridx];
    end
  end

  assign rd_data_o = hit_q ? rd_data_q : 8'd0;
endmodule

// ===== src/sector_unit_serializer.sv =====
// One input word at a time: the next word is taken in the cycle the result of the last one
// appears; input is not ready until the result is handed to the output register, which may
// still hold the previous word. A record start copies its postponed units byte by byte,
// headers included. Reset clears the walk state, the next command and all postponed entries
// (valid bits); the sector store holds no defined contents until written.
module sector_unit_serializer #(
  parameter int unsigned POSTPONED_DEPTH = 93
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sus_in_if.sink     in_i,
  sus_out_if.source  out_o
);
  import sus_pkg::*;

  localparam int unsigned IdxW = $clog2(POSTPONED_DEPTH);
  localparam logic [7:0]      PpTop     = 8'(POSTPONED_DEPTH - 1);
  localparam logic [IdxW-1:0] DestTop   = IdxW'(POSTPONED_DEPTH - 1);
  localparam logic [IdxW-1:0] DestDummy = IdxW'(POSTPONED_DEPTH - 5);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FLEN   = 4'd1;
  localparam logic [3:0] S_FD     = 4'd2;
  localparam logic [3:0] S_FNL    = 4'd3;
  localparam logic [3:0] S_SSTART = 4'd4;
  localparam logic [3:0] S_FLAG   = 4'd5;
  localparam logic [3:0] S_CMD0   = 4'd6;
  localparam logic [3:0] S_CMD1   = 4'd7;
  localparam logic [3:0] S_CMD2   = 4'd8;
  localparam logic [3:0] S_RCHK   = 4'd9;
  localparam logic [3:0] S_COPY   = 4'd10;
  localparam logic [3:0] S_REND   = 4'd11;
  localparam logic [3:0] S_RZERO  = 4'd12;
  localparam logic [3:0] S_PREP   = 4'd13;
  localparam logic [3:0] S_BEGIN  = 4'd14;
  localparam logic [3:0] S_EMIT   = 4'd15;

  logic [3:0]      state_q, state_d;
  logic [23:0]     cmd_q, cmd_d;
  logic [7:0]      wp_q, wp_d;
  logic [7:0]      bl_q, bl_d;
  logic [7:0]      cl_q, cl_d;
  logic            from_pp_q, from_pp_d;
  logic            sending_q, sending_d;
  logic [7:0]      rd_ptr_q, rd_ptr_d;
  logic [7:0]      pos_q, pos_d;
  logic [IdxW-1:0] dest_q, dest_d;
  logic [2:0]      cnt_q, cnt_d;
  res_t            res_q, res_d;
  logic            out_valid_q, out_valid_d;
  res_t            out_res_q, out_res_d;
  logic [23:0]     out_cmd_q, out_cmd_d;

  logic            accept;
  mem_wr_t         sec_wr;
  mem_wr_t         pp_wr;
  logic [7:0]      rd_addr;
  logic [7:0]      sec_rdata;
  logic [7:0]      pp_rdata;
  logic [7:0]      walk_rdata;
  logic [7:0]      sub_a, sub_b, sub_diff;
  logic            sub_borrow, sub_zero;
  logic            chain_now;
  logic            rec_stop;

  sus_sector_mem u_sector (
    .clk_i     (clk_i),
    .wr_i      (sec_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (sec_rdata)
  );

  sus_pp_mem #(.DEPTH(POSTPONED_DEPTH)) u_pp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (pp_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (pp_rdata)
  );

  sus_sub u_sub (
    .a_i      (sub_a),
    .b_i      (sub_b),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow),
    .zero_o   (sub_zero)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && (state_q == S_IDLE);
  assign walk_rdata = from_pp_q ? pp_rdata : sec_rdata;
  assign chain_now  = from_pp_q && (cl_q == LEN_CHAIN);
  assign rec_stop   = (sec_rdata == 8'd0) || (sec_rdata > LEN_MAX) || !sub_borrow;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    wp_d        = wp_q;
    bl_d        = bl_q;
    cl_d        = cl_q;
    from_pp_d   = from_pp_q;
    sending_d   = sending_q;
    rd_ptr_d    = rd_ptr_q;
    pos_d       = pos_q;
    dest_d      = dest_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    sec_wr      = '0;
    pp_wr       = '0;
    rd_addr     = rd_ptr_q;
    sub_a       = wp_q;
    sub_b       = cl_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_res_d   = out_res_q;
    out_cmd_d   = out_cmd_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          unique case (in_i.op)
            OP_WRITE: begin
              sec_wr       = '{en: 1'b1, addr: in_i.address, data: in_i.byte_value};
              res_d.status = ST_WRITTEN;
              state_d      = S_EMIT;
            end
            OP_SECTOR: begin
              from_pp_d = 1'b0;
              state_d   = S_SSTART;
            end
            OP_POSTPONED: begin
              from_pp_d = 1'b1;
              pos_d     = PpTop;
              state_d   = S_PREP;
            end
            OP_FETCH: begin
              if (!sending_q) begin
                res_d.status = ST_NO_MORE;
                state_d      = S_EMIT;
              end else if (bl_q == 8'd0) begin
                state_d = S_FLEN;
              end else begin
                state_d = S_FD;
              end
            end
          endcase
        end
      end

      // length byte: wp - cl, and the impossible-length check from the same subtract
      S_FLEN: begin
        sub_a = wp_q;
        sub_b = cl_q;
        if ((wp_q != 8'd0) && (sub_borrow || sub_zero)) begin
          sending_d    = 1'b0;
          res_d.status = ST_BAD_LEN;
        end else begin
          wp_d             = sub_diff;
          bl_d             = cl_q;
          rd_ptr_d         = wp_q - 8'd1;
          res_d.status     = ST_BYTE;
          res_d.is_length  = 1'b1;
          res_d.raw_byte   = cl_q;
          res_d.chain_head = chain_now;
        end
        state_d = S_EMIT;
      end

      // data byte from the read started while idle
      S_FD: begin
        res_d.status     = ST_BYTE;
        res_d.raw_byte   = walk_rdata;
        res_d.wire_pairs = encode_pairs(walk_rdata);
        res_d.chain_head = chain_now;
        bl_d             = bl_q - 8'd1;
        rd_ptr_d         = rd_ptr_q - 8'd1;
        rd_addr          = wp_q - 8'd1;
        state_d          = S_EMIT;
        if (bl_q == 8'd1) begin
          res_d.unit_last = 1'b1;
          if (wp_q > 8'd1) begin
            wp_d    = wp_q - 8'd1;
            state_d = S_FNL;
          end else begin
            cl_d          = 8'd0;
            sending_d     = 1'b0;
            res_d.job_end = from_pp_q && cmd_q[NEW_JOB_BIT];
          end
        end
      end

      // next unit length after the last data byte
      S_FNL: begin
        cl_d = walk_rdata;
        if (walk_rdata == 8'd0) begin
          sending_d     = 1'b0;
          res_d.job_end = from_pp_q && cmd_q[NEW_JOB_BIT];
        end
        state_d = S_EMIT;
      end

      S_SSTART: begin
        rd_addr = ADDR_FLAG;
        state_d = S_FLAG;
      end

      // flag byte decides where the walk begins
      S_FLAG: begin
        if ((sec_rdata & FLAG_MASK) == FLAG_FULL) begin
          wp_d         = 8'd0;
          bl_d         = 8'd0;
          cl_d         = LEN_FULL;
          sending_d    = 1'b1;
          res_d.status = ST_STARTED;
          state_d      = S_EMIT;
        end else if ((sec_rdata & FLAG_MASK) == FLAG_RECORD) begin
          rd_addr = ADDR_CMD_HI;
          state_d = S_CMD0;
        end else begin
          pos_d   = ADDR_LAST;
          state_d = S_PREP;
        end
      end

      // next command bytes
      S_CMD0: begin
        cmd_d[23:16] = sec_rdata;
        rd_addr      = ADDR_CMD_MID;
        state_d      = S_CMD1;
      end
      S_CMD1: begin
        cmd_d[15:8] = sec_rdata;
        rd_addr     = ADDR_CMD_LO;
        state_d     = S_CMD2;
      end
      S_CMD2: begin
        cmd_d[7:0] = sec_rdata;
        rd_addr    = ADDR_REC_START;
        pos_d      = ADDR_REC_START;
        dest_d     = DestTop;
        state_d    = S_RCHK;
      end

      // unit header: stop on zero, too long, or no room left
      S_RCHK: begin
        sub_a   = sec_rdata;
        sub_b   = 8'(dest_q);
        rd_addr = pos_q - 8'd1;
        if (rec_stop) begin
          state_d = S_REND;
        end else begin
          pp_wr   = '{en: 1'b1, addr: 8'(dest_q), data: sec_rdata};
          dest_d  = dest_q - IdxW'(1);
          pos_d   = pos_q - 8'd1;
          cnt_d   = sec_rdata[2:0];
          state_d = S_COPY;
        end
      end

      // copy one unit byte per cycle, next read already in flight
      S_COPY: begin
        pp_wr   = '{en: 1'b1, addr: 8'(dest_q), data: sec_rdata};
        dest_d  = dest_q - IdxW'(1);
        pos_d   = pos_q - 8'd1;
        cnt_d   = cnt_q - 3'd1;
        rd_addr = pos_q - 8'd1;
        if (cnt_q == 3'd1) begin
          state_d = S_RCHK;
        end
      end

      // dummy unit when nothing was postponed, then the terminating zero
      S_REND: begin
        if (dest_q == DestTop) begin
          pp_wr   = '{en: 1'b1, addr: PpTop, data: LEN_DUMMY};
          dest_d  = DestDummy;
          state_d = S_RZERO;
        end else begin
          pp_wr   = '{en: 1'b1, addr: 8'(dest_q), data: 8'd0};
          state_d = S_PREP;
        end
      end
      S_RZERO: begin
        pp_wr   = '{en: 1'b1, addr: 8'(dest_q), data: 8'd0};
        state_d = S_PREP;
      end

      S_PREP: begin
        rd_addr = pos_q;
        state_d = S_BEGIN;
      end

      // first length of the walk
      S_BEGIN: begin
        wp_d         = pos_q;
        bl_d         = 8'd0;
        cl_d         = walk_rdata;
        sending_d    = (walk_rdata != 8'd0);
        res_d.status = ST_STARTED;
        state_d      = S_EMIT;
      end

      // hand the word to the output register once it is free
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_cmd_d   = cmd_q;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      wp_q        <= '0;
      bl_q        <= '0;
      cl_q        <= '0;
      from_pp_q   <= 1'b0;
      sending_q   <= 1'b0;
      rd_ptr_q    <= '0;
      pos_q       <= '0;
      dest_q      <= '0;
      cnt_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_cmd_q   <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      wp_q        <= wp_d;
      bl_q        <= bl_d;
      cl_q        <= cl_d;
      from_pp_q   <= from_pp_d;
      sending_q   <= sending_d;
      rd_ptr_q    <= rd_ptr_d;
      pos_q       <= pos_d;
      dest_q      <= dest_d;
      cnt_q       <= cnt_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
      out_cmd_q   <= out_cmd_d;
    end
  end

  // output word
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_res_q.status;
  assign out_o.is_length    = out_res_q.is_length;
  assign out_o.raw_byte     = out_res_q.raw_byte;
  assign out_o.wire_pairs   = out_res_q.wire_pairs;
  assign out_o.chain_head   = out_res_q.chain_head;
  assign out_o.job_end      = out_res_q.job_end;
  assign out_o.unit_last    = out_res_q.unit_last;
  assign out_o.next_command = out_cmd_q;
endmodule
